[sv/sbt_pkg.sv]
// sbt_pkg: shared types, codes and character classes for the script byte tokenizer.
// No dependencies; imported by every module of the block.
package sbt_pkg;

   // default widths of the line and column counters
   localparam int LINE_BITS_DEF   = 24;
   localparam int COLUMN_BITS_DEF = 16;

   // most records one input item can cause, and the run count width
   localparam int MAX_RUN   = 8;
   localparam int CNT_W     = $clog2(MAX_RUN + 1);
   localparam int IDX_W     = $clog2(MAX_RUN);
   localparam int FIFO_DEPTH = 2;

   // input item kinds
   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_END  = 1'b1;

   // record codes
   localparam logic [1:0] REC_PAYLOAD = 2'd0;
   localparam logic [1:0] REC_TOKEN   = 2'd1;
   localparam logic [1:0] REC_ERROR   = 2'd2;

   // error codes
   localparam logic [1:0] ERR_NONE    = 2'd0;
   localparam logic [1:0] ERR_UNTERM  = 2'd1;
   localparam logic [1:0] ERR_CHAR    = 2'd2;

   // token kinds
   localparam logic [4:0] TK_END     = 5'd0;
   localparam logic [4:0] TK_NUMBER  = 5'd1;
   localparam logic [4:0] TK_STRING  = 5'd2;
   localparam logic [4:0] TK_IDENT   = 5'd3;
   localparam logic [4:0] TK_LPAREN  = 5'd4;
   localparam logic [4:0] TK_RPAREN  = 5'd5;
   localparam logic [4:0] TK_LBRACK  = 5'd6;
   localparam logic [4:0] TK_RBRACK  = 5'd7;
   localparam logic [4:0] TK_COMMA   = 5'd8;
   localparam logic [4:0] TK_ASSIGN  = 5'd9;
   localparam logic [4:0] TK_DOT     = 5'd10;
   localparam logic [4:0] TK_PLUS    = 5'd11;
   localparam logic [4:0] TK_MINUS   = 5'd12;
   localparam logic [4:0] TK_STAR    = 5'd13;
   localparam logic [4:0] TK_SLASH   = 5'd14;
   localparam logic [4:0] TK_PERCENT = 5'd15;
   localparam logic [4:0] TK_NEWLINE = 5'd16;

   // characters
   localparam logic [7:0] CH_BOM0   = 8'hEF;
   localparam logic [7:0] CH_BOM1   = 8'hBB;
   localparam logic [7:0] CH_BOM2   = 8'hBF;
   localparam logic [7:0] CH_HASH   = 8'h23;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_DOT    = 8'h2E;
   localparam logic [7:0] CH_LOW_E  = 8'h65;
   localparam logic [7:0] CH_UP_E   = 8'h45;
   localparam logic [7:0] CH_LOW_N  = 8'h6E;
   localparam logic [7:0] CH_LOW_T  = 8'h74;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_LBRACK = 8'h5B;
   localparam logic [7:0] CH_RBRACK = 8'h5D;
   localparam logic [7:0] CH_COMMA  = 8'h2C;
   localparam logic [7:0] CH_EQUAL  = 8'h3D;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_PCT    = 8'h25;
   localparam logic [7:0] CH_UNDER  = 8'h5F;

   // lexer modes
   typedef enum logic [3:0] {
      M_IDLE, M_COMMENT, M_IDENT, M_NUM, M_EXP_E, M_EXP_SIGN, M_EXP_DIG,
      M_DOT, M_JOIN, M_JOIN_CR, M_STR, M_STR_ESC
   } mode_type;

   // one result record without its column
   typedef struct packed {
      logic [1:0] rec;
      logic [4:0] kind;
      logic [1:0] code;
      logic [7:0] pay;
   } rec_body_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } fifo_stat_type;

   function automatic logic is_digit(input logic [7:0] c);
      return (c >= 8'h30) && (c <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] c);
      return ((c >= 8'h61) && (c <= 8'h7A)) || ((c >= 8'h41) && (c <= 8'h5A)) ||
             (c == CH_UNDER);
   endfunction

   function automatic logic is_blank(input logic [7:0] c);
      return (c == CH_SPACE) || (c == CH_TAB) || (c == CH_CR);
   endfunction

   // punctuator token kind, TK_END when the byte is none
   function automatic logic [4:0] punct_kind(input logic [7:0] c);
      logic [4:0] k;
      case (c)
         CH_LPAREN: k = TK_LPAREN;
         CH_RPAREN: k = TK_RPAREN;
         CH_LBRACK: k = TK_LBRACK;
         CH_RBRACK: k = TK_RBRACK;
         CH_COMMA:  k = TK_COMMA;
         CH_EQUAL:  k = TK_ASSIGN;
         CH_DOT:    k = TK_DOT;
         CH_PLUS:   k = TK_PLUS;
         CH_MINUS:  k = TK_MINUS;
         CH_STAR:   k = TK_STAR;
         CH_SLASH:  k = TK_SLASH;
         CH_PCT:    k = TK_PERCENT;
         default:   k = TK_END;
      endcase
      return k;
   endfunction

   // expected byte of the byte-order mark at a position
   function automatic logic [7:0] bom_byte(input logic [1:0] pos);
      logic [7:0] b;
      case (pos)
         2'd0:    b = CH_BOM0;
         2'd1:    b = CH_BOM1;
         default: b = CH_BOM2;
      endcase
      return b;
   endfunction

endpackage

[sv/sbt_fifo.sv]
// sbt_fifo: small register queue of result runs between lexer front and record back end.
// Depends on sbt_pkg for the status struct.
module sbt_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = sbt_pkg::FIFO_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      push_data,
   input  logic                  pop,
   output logic [WIDTH-1:0]      head_data,
   output sbt_pkg::fifo_stat_type stat
);
   import sbt_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_BITS = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);

   logic [WIDTH-1:0]    mem_ff [DEPTH];
   logic [PTR_W-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_BITS-1:0] cnt_ff, cnt_in;

   // pointer and fill count
   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (push) begin
         wr_in = (wr_ff == LAST_PTR) ? '0 : wr_ff + 1'b1;
      end
      if (pop) begin
         rd_in = (rd_ff == LAST_PTR) ? '0 : rd_ff + 1'b1;
      end
      if (push && !pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (pop && !push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // entry storage, no reset needed
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

   assign head_data  = mem_ff[rd_ff];
   assign stat.full  = (cnt_ff == CNT_BITS'(DEPTH));
   assign stat.empty = (cnt_ff == '0);

endmodule

[sv/sbt_front.sv]
// sbt_front: accepts source items, runs the lexer state update and builds the run of
// result records each item causes. Depends on sbt_pkg.
module sbt_front #(
   parameter int LINE_BITS   = sbt_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = sbt_pkg::COLUMN_BITS_DEF,
   parameter int ENTRY_W     = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [7:0]             req_data_byte,
   input  sbt_pkg::fifo_stat_type stat,
   output logic                   push,
   output logic [ENTRY_W-1:0]     push_data
);
   import sbt_pkg::*;

   localparam logic [COLUMN_BITS-1:0] COL_TOP  = '1;
   localparam logic [LINE_BITS-1:0]   LINE_TOP = '1;
   localparam logic [COLUMN_BITS-1:0] COL_ONE  = COLUMN_BITS'(1);

   typedef struct packed {
      mode_type               mode;
      logic [COLUMN_BITS-1:0] tsc;
      logic [COLUMN_BITS-1:0] hcol;
      logic [7:0]             h0;
      logic [7:0]             h1;
      logic [1:0]             hcnt;
      logic                   failed;
   } lex_type;

   typedef struct packed {
      rec_body_type           body;
      logic [COLUMN_BITS-1:0] col;
   } rec_type;

   typedef struct packed {
      rec_type [2:0] r;
      logic [1:0]    n;
      logic          nl;
      logic          bt;
      lex_type       st;
   } step_type;

   lex_type                lex_ff, lex_in;
   logic [1:0]             bom_ff, bom_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [COLUMN_BITS-1:0] colc_ff, colc_in;
   step_type               src [5];
   rec_type [MAX_RUN-1:0]  recs;
   logic [CNT_W-1:0]       n_rec;
   logic                   accept;

   function automatic logic [COLUMN_BITS-1:0] sat_col(input logic [COLUMN_BITS-1:0] x);
      return (x == COL_TOP) ? x : x + 1'b1;
   endfunction

   // lexer state at the start of a source
   function automatic lex_type lex_clear();
      lex_type v;
      v      = '0;
      v.mode = M_IDLE;
      v.tsc  = COL_ONE;
      v.hcol = COL_ONE;
      return v;
   endfunction

   function automatic rec_type mk(input logic [1:0] rc, input logic [4:0] k,
                                  input logic [1:0] cd, input logic [7:0] p,
                                  input logic [COLUMN_BITS-1:0] col);
      rec_type r;
      r.body.rec  = rc;
      r.body.kind = k;
      r.body.code = cd;
      r.body.pay  = p;
      r.col       = col;
      return r;
   endfunction

   function automatic step_type push_rec(input step_type s, input rec_type r);
      step_type t;
      t = s;
      t.r[t.n] = r;
      t.n = t.n + 2'd1;
      return t;
   endfunction

   function automatic step_type raise(input step_type s, input logic [1:0] cd,
                                      input logic [7:0] p, input logic [COLUMN_BITS-1:0] col);
      step_type t;
      t = push_rec(s, mk(REC_ERROR, TK_END, cd, p, col));
      t.st.failed = 1'b1;
      t.st.mode   = M_IDLE;
      t.st.hcnt   = 2'd0;
      return t;
   endfunction

   // handling of a byte with no token in progress
   function automatic step_type idle(input lex_type st, input logic [7:0] c,
                                     input logic [COLUMN_BITS-1:0] col);
      step_type s;
      s = '0;
      s.st = st;
      if (!st.failed) begin
         s.st.mode = M_IDLE;
         if (c == CH_HASH) begin
            s.st.mode = M_COMMENT;
         end else if (c == CH_LF) begin
            s = push_rec(s, mk(REC_TOKEN, TK_NEWLINE, ERR_NONE, 8'h00, col));
            s.nl = 1'b1;
         end else if (is_blank(c)) begin
            s.st.mode = M_IDLE;
         end else if (c == CH_BSLASH) begin
            s.st.mode = M_JOIN;
            s.st.hcol = col;
         end else if (is_digit(c)) begin
            s.st.mode = M_NUM;
            s.st.tsc  = col;
            s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
         end else if (c == CH_DOT) begin
            s.st.mode = M_DOT;
            s.st.tsc  = col;
         end else if (is_alpha(c)) begin
            s.st.mode = M_IDENT;
            s.st.tsc  = col;
            s = push_rec(s, mk(REC_PAYLOAD, TK_IDENT, ERR_NONE, c, col));
         end else if (c == CH_QUOTE) begin
            s.st.mode = M_STR;
            s.st.tsc  = col;
         end else if (punct_kind(c) != TK_END) begin
            s = push_rec(s, mk(REC_TOKEN, punct_kind(c), ERR_NONE, 8'h00, col));
         end else begin
            s = raise(s, ERR_CHAR, c, col);
         end
      end
      return s;
   endfunction

   // closes a token with a record, then hands the byte to idle handling
   function automatic step_type close_then_idle(input step_type s, input logic [4:0] k,
                                                input logic [7:0] c,
                                                input logic [COLUMN_BITS-1:0] col);
      step_type t;
      step_type u;
      t = push_rec(s, mk(REC_TOKEN, k, ERR_NONE, 8'h00, s.st.tsc));
      u = idle(t.st, c, col);
      t.st = u.st;
      t.nl = u.nl;
      if (u.n != 2'd0) begin
         t = push_rec(t, u.r[0]);
      end
      return t;
   endfunction

   // one lexer step; bt asks for an exponent backtrack with nothing emitted
   function automatic step_type step(input lex_type st, input logic [7:0] c,
                                     input logic [COLUMN_BITS-1:0] col);
      step_type s;
      logic [7:0] esc;
      s = '0;
      s.st = st;
      esc = (c == CH_LOW_N) ? CH_LF : ((c == CH_LOW_T) ? CH_TAB : c);
      if (!st.failed) begin
         case (st.mode)
            M_COMMENT: begin
               if (c == CH_LF) s = idle(st, c, col);
            end
            M_IDENT: begin
               if (is_alpha(c) || is_digit(c)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_IDENT, ERR_NONE, c, col));
               end else begin
                  s = close_then_idle(s, TK_IDENT, c, col);
               end
            end
            M_NUM: begin
               if (is_digit(c) || (c == CH_DOT)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
               end else if ((c == CH_LOW_E) || (c == CH_UP_E)) begin
                  s.st.h0   = c;
                  s.st.hcnt = 2'd1;
                  s.st.hcol = col;
                  s.st.mode = M_EXP_E;
               end else begin
                  s = close_then_idle(s, TK_NUMBER, c, col);
               end
            end
            M_EXP_E: begin
               if ((c == CH_PLUS) || (c == CH_MINUS)) begin
                  s.st.h1   = c;
                  s.st.hcnt = 2'd2;
                  s.st.mode = M_EXP_SIGN;
               end else if (is_digit(c)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, st.h0, col));
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
                  s.st.hcnt = 2'd0;
                  s.st.mode = M_EXP_DIG;
               end else begin
                  s.bt = 1'b1;
               end
            end
            M_EXP_SIGN: begin
               if (is_digit(c)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, st.h0, col));
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, st.h1, col));
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
                  s.st.hcnt = 2'd0;
                  s.st.mode = M_EXP_DIG;
               end else begin
                  s.bt = 1'b1;
               end
            end
            M_EXP_DIG: begin
               if (is_digit(c)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
               end else begin
                  s = close_then_idle(s, TK_NUMBER, c, col);
               end
            end
            M_DOT: begin
               if (is_digit(c)) begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, CH_DOT, col));
                  s = push_rec(s, mk(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col));
                  s.st.mode = M_NUM;
               end else begin
                  s = close_then_idle(s, TK_DOT, c, col);
               end
            end
            M_JOIN: begin
               if (c == CH_LF) begin
                  s.st.mode = M_IDLE;
                  s.nl = 1'b1;
               end else if (c == CH_CR) begin
                  s.st.mode = M_JOIN_CR;
               end else begin
                  s = raise(s, ERR_CHAR, CH_BSLASH, st.hcol);
               end
            end
            M_JOIN_CR: begin
               if (c == CH_LF) begin
                  s.st.mode = M_IDLE;
                  s.nl = 1'b1;
               end else begin
                  s = idle(st, c, col);
               end
            end
            M_STR: begin
               if (c == CH_QUOTE) begin
                  s = push_rec(s, mk(REC_TOKEN, TK_STRING, ERR_NONE, 8'h00, st.tsc));
                  s.st.mode = M_IDLE;
               end else if (c == CH_LF) begin
                  s = raise(s, ERR_UNTERM, 8'h00, st.tsc);
               end else if (c == CH_BSLASH) begin
                  s.st.mode = M_STR_ESC;
               end else begin
                  s = push_rec(s, mk(REC_PAYLOAD, TK_STRING, ERR_NONE, c, col));
               end
            end
            M_STR_ESC: begin
               s = push_rec(s, mk(REC_PAYLOAD, TK_STRING, ERR_NONE, esc, col));
               s.st.mode = M_STR;
            end
            default: s = idle(st, c, col);
         endcase
      end
      return s;
   endfunction

   assign req_stall = stat.full;
   assign accept    = req_valid && !req_stall;

   // lexer update and record sources for one item
   always_comb begin
      step_type blank;
      step_type fin;
      step_type cl;
      lex_type  cur;
      lex_type  base;
      logic     consumed;
      blank    = '0;
      fin      = '0;
      cl       = '0;
      cur      = lex_ff;
      base     = lex_ff;
      consumed = 1'b0;
      for (int i = 0; i < 5; i++) src[i] = '0;
      lex_in  = lex_ff;
      bom_in  = bom_ff;
      line_in = line_ff;
      colc_in = colc_ff;

      if (req_kind == KIND_END) begin
         // end of source: pending partial mark, backtrack, close, end token
         fin = blank;
         fin.st = lex_ff;
         if (!lex_ff.failed && ((bom_ff == 2'd1) || (bom_ff == 2'd2))) begin
            fin = raise(fin, ERR_CHAR, CH_BOM0, COL_ONE);
         end
         src[0] = fin;
         base = fin.st;
         cur  = fin.st;
         if (!base.failed && ((base.mode == M_EXP_E) || (base.mode == M_EXP_SIGN))) begin
            src[1] = push_rec(blank, mk(REC_TOKEN, TK_NUMBER, ERR_NONE, 8'h00, base.tsc));
            cur.hcnt = 2'd0;
            cur.mode = M_IDLE;
            src[2] = step(cur, base.h0, base.hcol);
            cur = src[2].st;
            if (base.hcnt == 2'd2) begin
               src[3] = step(cur, base.h1, sat_col(base.hcol));
               cur = src[3].st;
            end
         end
         cl.st = cur;
         if (!cur.failed) begin
            case (cur.mode) inside
               M_IDENT: cl = push_rec(cl, mk(REC_TOKEN, TK_IDENT, ERR_NONE, 8'h00, cur.tsc));
               M_NUM, M_EXP_DIG:
                  cl = push_rec(cl, mk(REC_TOKEN, TK_NUMBER, ERR_NONE, 8'h00, cur.tsc));
               M_DOT: cl = push_rec(cl, mk(REC_TOKEN, TK_DOT, ERR_NONE, 8'h00, cur.tsc));
               M_JOIN: cl = raise(cl, ERR_CHAR, CH_BSLASH, cur.hcol);
               M_STR, M_STR_ESC: cl = raise(cl, ERR_UNTERM, 8'h00, cur.tsc);
               default: cl = cl;
            endcase
            if (!cl.st.failed) begin
               cl = push_rec(cl, mk(REC_TOKEN, TK_END, ERR_NONE, 8'h00, colc_ff));
            end
         end
         src[4] = cl;
         // fresh source after the end item
         lex_in      = '0;
         lex_in.mode = M_IDLE;
         lex_in.tsc  = COL_ONE;
         lex_in.hcol = COL_ONE;
         bom_in      = 2'd0;
         line_in     = LINE_BITS'(1);
         colc_in     = COL_ONE;
      end else if (!lex_ff.failed) begin
         // byte-order mark at the head of the source
         if (bom_ff != 2'd3) begin
            if (req_data_byte == bom_byte(bom_ff)) begin
               bom_in   = bom_ff + 2'd1;
               consumed = 1'b1;
            end else if (bom_ff != 2'd0) begin
               fin = blank;
               fin.st = lex_ff;
               src[0] = raise(fin, ERR_CHAR, CH_BOM0, COL_ONE);
               lex_in = src[0].st;
               consumed = 1'b1;
            end else begin
               bom_in = 2'd3;
            end
         end
         if (!consumed) begin
            fin = step(lex_ff, req_data_byte, colc_ff);
            if (fin.bt) begin
               // exponent backtrack: close the number, relex the held bytes
               src[1] = push_rec(blank, mk(REC_TOKEN, TK_NUMBER, ERR_NONE, 8'h00, lex_ff.tsc));
               cur.hcnt = 2'd0;
               cur.mode = M_IDLE;
               src[2] = step(cur, lex_ff.h0, lex_ff.hcol);
               cur = src[2].st;
               if (lex_ff.hcnt == 2'd2) begin
                  src[3] = step(cur, lex_ff.h1, sat_col(lex_ff.hcol));
                  cur = src[3].st;
               end
               fin = step(cur, req_data_byte, colc_ff);
            end
            src[4] = fin;
            lex_in = fin.st;
            if (fin.nl) begin
               line_in = (line_ff == LINE_TOP) ? line_ff : line_ff + 1'b1;
               colc_in = COL_ONE;
            end else begin
               colc_in = sat_col(colc_ff);
            end
         end
      end
   end

   // pack the sources into one run
   always_comb begin
      n_rec = '0;
      recs  = '0;
      for (int i = 0; i < 5; i++) begin
         for (int j = 0; j < 3; j++) begin
            if (2'(j) < src[i].n) begin
               recs[n_rec[IDX_W-1:0]] = src[i].r[j];
               n_rec = n_rec + 1'b1;
            end
         end
      end
   end

   assign push      = accept && (n_rec != '0);
   assign push_data = {n_rec, line_ff, recs};

   always_ff @(posedge clock) begin
      if (reset) begin
         lex_ff  <= lex_clear();
         bom_ff  <= 2'd0;
         line_ff <= LINE_BITS'(1);
         colc_ff <= COL_ONE;
      end else if (accept) begin
         lex_ff  <= lex_in;
         bom_ff  <= bom_in;
         line_ff <= line_in;
         colc_ff <= colc_in;
      end
   end

endmodule

[sv/sbt_back.sv]
// sbt_back: walks the run at the queue head and presents one result record per cycle
// while rsp_stall is low. Depends on sbt_pkg.
module sbt_back #(
   parameter int LINE_BITS   = sbt_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = sbt_pkg::COLUMN_BITS_DEF,
   parameter int ENTRY_W     = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic [ENTRY_W-1:0]     head_data,
   input  sbt_pkg::fifo_stat_type stat,
   output logic                   pop,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_record,
   output logic [4:0]             rsp_token_kind,
   output logic [1:0]             rsp_error_code,
   output logic [7:0]             rsp_payload,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [COLUMN_BITS-1:0] rsp_column,
   output logic                   rsp_last_of_run
);
   import sbt_pkg::*;

   localparam int BODY_W = $bits(rec_body_type);
   localparam int REC_W  = BODY_W + COLUMN_BITS;

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] cnt;
   logic [REC_W-1:0] rec;
   rec_body_type     body;
   logic             accept;

   // unpack the current record of the head run
   assign cnt  = head_data[ENTRY_W-1 -: CNT_W];
   assign rec  = head_data[idx_ff*REC_W +: REC_W];
   assign body = rec[REC_W-1 -: BODY_W];

   assign rsp_valid       = !stat.empty;
   assign rsp_record      = body.rec;
   assign rsp_token_kind  = body.kind;
   assign rsp_error_code  = body.code;
   assign rsp_payload     = body.pay;
   assign rsp_column      = rec[COLUMN_BITS-1:0];
   assign rsp_line_number = head_data[MAX_RUN*REC_W +: LINE_BITS];
   assign rsp_last_of_run = ({1'b0, idx_ff} == (cnt - CNT_W'(1)));

   assign accept = rsp_valid && !rsp_stall;
   assign pop    = accept && rsp_last_of_run;

   // record index within the run
   always_comb begin
      idx_in = idx_ff;
      if (pop) begin
         idx_in = '0;
      end else if (accept) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= '0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule

[sv/script_byte_tokenizer.sv]
// script_byte_tokenizer: top level of the streaming script lexer.
// Depends on sbt_pkg, sbt_front, sbt_fifo and sbt_back.
//
//   channel  direction  handshake             payload
//   req_     in         req_valid/req_stall   kind, data_byte
//   rsp_     out        rsp_valid/rsp_stall   record, token_kind, error_code, payload,
//                                             line_number, column, last_of_run
//
// One item is taken per cycle while the run queue is not full; its whole lexer update,
// backtrack included, is done in the front stage in that cycle. Results leave one record
// per cycle from the back end while the output is not stalled; the run of an item is
// registered in the run queue first. The two-entry run queue sets how far input runs
// ahead of a stalled output. Reset is synchronous; the block is ready once it drops.
module script_byte_tokenizer #(
   parameter int LINE_BITS   = sbt_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = sbt_pkg::COLUMN_BITS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_kind,
   input  logic [7:0]             req_data_byte,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic [1:0]             rsp_record,
   output logic [4:0]             rsp_token_kind,
   output logic [1:0]             rsp_error_code,
   output logic [7:0]             rsp_payload,
   output logic [LINE_BITS-1:0]   rsp_line_number,
   output logic [COLUMN_BITS-1:0] rsp_column,
   output logic                   rsp_last_of_run
);
   import sbt_pkg::*;

   localparam int REC_W   = $bits(rec_body_type) + COLUMN_BITS;
   localparam int ENTRY_W = CNT_W + LINE_BITS + MAX_RUN * REC_W;

   fifo_stat_type      stat;
   logic               push, pop;
   logic [ENTRY_W-1:0] push_data, head_data;

   sbt_front #(
      .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .ENTRY_W(ENTRY_W)
   ) u_front (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .req_kind(req_kind), .req_data_byte(req_data_byte),
      .stat(stat), .push(push), .push_data(push_data)
   );

   sbt_fifo #(.WIDTH(ENTRY_W), .DEPTH(FIFO_DEPTH)) u_fifo (
      .clock(clock), .reset(reset),
      .push(push), .push_data(push_data),
      .pop(pop), .head_data(head_data), .stat(stat)
   );

   sbt_back #(
      .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS), .ENTRY_W(ENTRY_W)
   ) u_back (
      .clock(clock), .reset(reset),
      .head_data(head_data), .stat(stat), .pop(pop),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .rsp_record(rsp_record), .rsp_token_kind(rsp_token_kind),
      .rsp_error_code(rsp_error_code), .rsp_payload(rsp_payload),
      .rsp_line_number(rsp_line_number), .rsp_column(rsp_column),
      .rsp_last_of_run(rsp_last_of_run)
   );

endmodule

[sv/sbt_checker.sv]
// sbt_checker: port-level assertions for the script byte tokenizer, bound to its top.
// Depends on sbt_pkg and script_byte_tokenizer.
module sbt_checker #(
   parameter int LINE_BITS   = sbt_pkg::LINE_BITS_DEF,
   parameter int COLUMN_BITS = sbt_pkg::COLUMN_BITS_DEF
) (
   input logic                   clock,
   input logic                   reset,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input logic [1:0]             rsp_record,
   input logic [4:0]             rsp_token_kind,
   input logic [1:0]             rsp_error_code,
   input logic [7:0]             rsp_payload,
   input logic [LINE_BITS-1:0]   rsp_line_number,
   input logic [COLUMN_BITS-1:0] rsp_column,
   input logic                   rsp_last_of_run
);
   import sbt_pkg::*;

   // token records carry no error and no byte
   a_token_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record == REC_TOKEN) |->
         (rsp_error_code == ERR_NONE) && (rsp_payload == 8'h00))
      else $error("token record with error code or payload");

   // an error record has a code and ends its run
   a_error_ends_run: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record == REC_ERROR) |->
         (rsp_error_code != ERR_NONE) && rsp_last_of_run && (rsp_token_kind == TK_END))
      else $error("malformed error record");

   // a newline token always ends its run
   a_newline_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_record == REC_TOKEN) && (rsp_token_kind == TK_NEWLINE) |->
         rsp_last_of_run)
      else $error("newline token not last of its run");

   // line and column stay at one or above
   a_position_nonzero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_line_number != '0) && (rsp_column != '0))
      else $error("zero line or column");

   // stalled result holds
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_record) &&
         $stable(rsp_payload) && $stable(rsp_column) && $stable(rsp_last_of_run))
      else $error("stalled result changed");

endmodule

bind script_byte_tokenizer sbt_checker #(
   .LINE_BITS(LINE_BITS), .COLUMN_BITS(COLUMN_BITS)
) u_sbt_checker (
   .clock(clock), .reset(reset),
   .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
   .rsp_record(rsp_record), .rsp_token_kind(rsp_token_kind),
   .rsp_error_code(rsp_error_code), .rsp_payload(rsp_payload),
   .rsp_line_number(rsp_line_number), .rsp_column(rsp_column),
   .rsp_last_of_run(rsp_last_of_run)
);

[tb/script_byte_tokenizer_checker.sv]
// script_byte_tokenizer_checker: watches both channels, predicts the token stream
// and compares every result item. Depends on sbt_pkg for types and codes.
`timescale 1ns / 100ps
module script_byte_tokenizer_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_stall,
   input  logic        req_kind,
   input  logic [7:0]  req_data_byte,
   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic [1:0]  rsp_record,
   input  logic [4:0]  rsp_token_kind,
   input  logic [1:0]  rsp_error_code,
   input  logic [7:0]  rsp_payload,
   input  logic [23:0] rsp_line_number,
   input  logic [15:0] rsp_column,
   input  logic        rsp_last_of_run,
   output int          fail_count,
   output int          pending
);
   import sbt_pkg::*;

   localparam logic [23:0] LINE_MAX = 24'hFFFFFF;
   localparam logic [15:0] COL_MAX  = 16'hFFFF;

   typedef struct {
      logic [1:0]  rec;
      logic [4:0]  kind;
      logic [1:0]  code;
      logic [7:0]  pay;
      logic [23:0] line;
      logic [15:0] col;
      logic        last;
   } token_rec_t;

   token_rec_t expected_tokens[$];
   token_rec_t run_recs[$];

   // lexer state mirror
   mode_type    lex_mode;
   logic [1:0]  bom_pos;
   logic [23:0] line_cnt;
   logic [15:0] col_cnt, tok_col, held_col;
   logic [7:0]  held0, held1;
   int          held_n;
   bit          lex_failed;

   function automatic bit digit_ch(logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit alpha_ch(logic [7:0] c);
      return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == CH_UNDER;
   endfunction

   function automatic logic [4:0] punct_of(logic [7:0] c);
      case (c)
         CH_LPAREN: return TK_LPAREN;
         CH_RPAREN: return TK_RPAREN;
         CH_LBRACK: return TK_LBRACK;
         CH_RBRACK: return TK_RBRACK;
         CH_COMMA:  return TK_COMMA;
         CH_EQUAL:  return TK_ASSIGN;
         CH_DOT:    return TK_DOT;
         CH_PLUS:   return TK_PLUS;
         CH_MINUS:  return TK_MINUS;
         CH_STAR:   return TK_STAR;
         CH_SLASH:  return TK_SLASH;
         CH_PCT:    return TK_PERCENT;
         default:   return TK_END;
      endcase
   endfunction

   function automatic void clear_lexer();
      lex_mode = M_IDLE;
      bom_pos = 0;
      line_cnt = 1;
      col_cnt = 1;
      tok_col = 1;
      held_col = 1;
      held0 = 0;
      held1 = 0;
      held_n = 0;
      lex_failed = 0;
   endfunction

   function automatic void add_rec(logic [1:0] rec, logic [4:0] kind, logic [1:0] code,
                                   logic [7:0] pay, logic [15:0] col);
      token_rec_t r;
      if (run_recs.size() >= MAX_RUN) return;
      r.rec = rec; r.kind = kind; r.code = code; r.pay = pay;
      r.line = line_cnt; r.col = col; r.last = 0;
      run_recs.insert(run_recs.size(), r);
   endfunction

   function automatic void flag_error(logic [1:0] code, logic [7:0] pay, logic [15:0] col);
      add_rec(REC_ERROR, TK_END, code, pay, col);
      lex_failed = 1;
      lex_mode = M_IDLE;
      held_n = 0;
   endfunction

   // byte seen with no token open; returns 1 when a line ends
   function automatic bit lex_idle(logic [7:0] c, logic [15:0] col);
      logic [4:0] pk;
      if (lex_failed) return 0;
      lex_mode = M_IDLE;
      if (c == CH_HASH) begin
         lex_mode = M_COMMENT;
         return 0;
      end
      if (c == CH_LF) begin
         add_rec(REC_TOKEN, TK_NEWLINE, ERR_NONE, 0, col);
         return 1;
      end
      if (c == CH_SPACE || c == CH_TAB || c == CH_CR) return 0;
      if (c == CH_BSLASH) begin
         lex_mode = M_JOIN;
         held_col = col;
         return 0;
      end
      if (digit_ch(c)) begin
         lex_mode = M_NUM; tok_col = col;
         add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
         return 0;
      end
      if (c == CH_DOT) begin
         lex_mode = M_DOT; tok_col = col;
         return 0;
      end
      if (alpha_ch(c)) begin
         lex_mode = M_IDENT; tok_col = col;
         add_rec(REC_PAYLOAD, TK_IDENT, ERR_NONE, c, col);
         return 0;
      end
      if (c == CH_QUOTE) begin
         lex_mode = M_STR; tok_col = col;
         return 0;
      end
      pk = punct_of(c);
      if (pk != TK_END) add_rec(REC_TOKEN, pk, ERR_NONE, 0, col);
      else flag_error(ERR_CHAR, c, col);
      return 0;
   endfunction

   // number ends before a dangling exponent; held bytes are lexed again
   function automatic void undo_exponent();
      logic [7:0] h0, h1;
      int n;
      int unsigned cc;
      h0 = held0; h1 = held1; n = held_n;
      add_rec(REC_TOKEN, TK_NUMBER, ERR_NONE, 0, tok_col);
      held_n = 0;
      lex_mode = M_IDLE;
      for (int k = 0; k < n && k < 2; k++) begin
         cc = int'(held_col) + k;
         if (cc > COL_MAX) cc = COL_MAX;
         void'(lex_byte(k == 0 ? h0 : h1, cc[15:0]));
      end
   endfunction

   function automatic bit lex_byte(logic [7:0] c, logic [15:0] col);
      if (lex_failed) return 0;
      case (lex_mode)
         M_COMMENT: begin
            if (c == CH_LF) return lex_idle(c, col);
            return 0;
         end
         M_IDENT: begin
            if (alpha_ch(c) || digit_ch(c)) begin
               add_rec(REC_PAYLOAD, TK_IDENT, ERR_NONE, c, col);
               return 0;
            end
            add_rec(REC_TOKEN, TK_IDENT, ERR_NONE, 0, tok_col);
            return lex_idle(c, col);
         end
         M_NUM: begin
            if (digit_ch(c) || c == CH_DOT) begin
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
               return 0;
            end
            if (c == CH_LOW_E || c == CH_UP_E) begin
               held0 = c; held_n = 1; held_col = col;
               lex_mode = M_EXP_E;
               return 0;
            end
            add_rec(REC_TOKEN, TK_NUMBER, ERR_NONE, 0, tok_col);
            return lex_idle(c, col);
         end
         M_EXP_E: begin
            if (c == CH_PLUS || c == CH_MINUS) begin
               held1 = c; held_n = 2;
               lex_mode = M_EXP_SIGN;
               return 0;
            end
            if (digit_ch(c)) begin
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, held0, col);
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
               held_n = 0; lex_mode = M_EXP_DIG;
               return 0;
            end
            undo_exponent();
            return lex_byte(c, col);
         end
         M_EXP_SIGN: begin
            if (digit_ch(c)) begin
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, held0, col);
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, held1, col);
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
               held_n = 0; lex_mode = M_EXP_DIG;
               return 0;
            end
            undo_exponent();
            return lex_byte(c, col);
         end
         M_EXP_DIG: begin
            if (digit_ch(c)) begin
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
               return 0;
            end
            add_rec(REC_TOKEN, TK_NUMBER, ERR_NONE, 0, tok_col);
            return lex_idle(c, col);
         end
         M_DOT: begin
            if (digit_ch(c)) begin
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, CH_DOT, col);
               add_rec(REC_PAYLOAD, TK_NUMBER, ERR_NONE, c, col);
               lex_mode = M_NUM;
               return 0;
            end
            add_rec(REC_TOKEN, TK_DOT, ERR_NONE, 0, tok_col);
            return lex_idle(c, col);
         end
         M_JOIN: begin
            if (c == CH_LF) begin
               lex_mode = M_IDLE;
               return 1;
            end
            if (c == CH_CR) begin
               lex_mode = M_JOIN_CR;
               return 0;
            end
            flag_error(ERR_CHAR, CH_BSLASH, held_col);
            return 0;
         end
         M_JOIN_CR: begin
            if (c == CH_LF) begin
               lex_mode = M_IDLE;
               return 1;
            end
            return lex_idle(c, col);
         end
         M_STR: begin
            if (c == CH_QUOTE) begin
               add_rec(REC_TOKEN, TK_STRING, ERR_NONE, 0, tok_col);
               lex_mode = M_IDLE;
               return 0;
            end
            if (c == CH_LF) begin
               flag_error(ERR_UNTERM, 0, tok_col);
               return 0;
            end
            if (c == CH_BSLASH) begin
               lex_mode = M_STR_ESC;
               return 0;
            end
            add_rec(REC_PAYLOAD, TK_STRING, ERR_NONE, c, col);
            return 0;
         end
         M_STR_ESC: begin
            add_rec(REC_PAYLOAD, TK_STRING, ERR_NONE,
                    c == CH_LOW_N ? CH_LF : (c == CH_LOW_T ? CH_TAB : c), col);
            lex_mode = M_STR;
            return 0;
         end
         default: return lex_idle(c, col);
      endcase
   endfunction

   // close whatever is open at end of source, then the end token
   function automatic void close_source();
      if (!lex_failed && (bom_pos == 1 || bom_pos == 2)) flag_error(ERR_CHAR, CH_BOM0, 1);
      for (int g = 0; g < 4 && !lex_failed; g++) begin
         if (lex_mode == M_EXP_E || lex_mode == M_EXP_SIGN) begin
            undo_exponent();
            continue;
         end
         case (lex_mode)
            M_IDENT:            add_rec(REC_TOKEN, TK_IDENT, ERR_NONE, 0, tok_col);
            M_NUM, M_EXP_DIG:   add_rec(REC_TOKEN, TK_NUMBER, ERR_NONE, 0, tok_col);
            M_DOT:              add_rec(REC_TOKEN, TK_DOT, ERR_NONE, 0, tok_col);
            M_JOIN:             flag_error(ERR_CHAR, CH_BSLASH, held_col);
            M_STR, M_STR_ESC:   flag_error(ERR_UNTERM, 0, tok_col);
            default: ;
         endcase
         break;
      end
      if (!lex_failed) add_rec(REC_TOKEN, TK_END, ERR_NONE, 0, col_cnt);
   endfunction

   // expected records of one accepted input item
   function automatic void predict_item(logic kind, logic [7:0] c);
      bit used, nl;
      run_recs.delete();
      if (kind == KIND_END) begin
         close_source();
         clear_lexer();
      end else if (!lex_failed) begin
         used = 0;
         if (bom_pos < 3) begin
            if (c == (bom_pos == 0 ? CH_BOM0 : (bom_pos == 1 ? CH_BOM1 : CH_BOM2))) begin
               bom_pos++;
               used = 1;
            end else if (bom_pos != 0) begin
               flag_error(ERR_CHAR, CH_BOM0, 1);
               used = 1;
            end else begin
               bom_pos = 3;
            end
         end
         if (!used) begin
            nl = lex_byte(c, col_cnt);
            if (nl) begin
               if (line_cnt < LINE_MAX) line_cnt++;
               col_cnt = 1;
            end else if (col_cnt < COL_MAX) begin
               col_cnt++;
            end
         end
      end
      if (run_recs.size() > 0) run_recs[run_recs.size() - 1].last = 1;
      foreach (run_recs[i]) expected_tokens.insert(expected_tokens.size(), run_recs[i]);
   endfunction

   function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
         fail_count++;
      end
   endfunction

   assign pending = expected_tokens.size();

   // predict on accepted input, compare on accepted output
   always @(posedge clock) begin
      token_rec_t e;
      if (reset) begin
         clear_lexer();
         expected_tokens.delete();
      end else begin
         if (req_valid && !req_stall) predict_item(req_kind, req_data_byte);
         if (rsp_valid && !rsp_stall) begin
            if (expected_tokens.size() == 0) begin
               $display("%0t: unexpected result item record %0d kind %0d", $time,
                        rsp_record, rsp_token_kind);
               fail_count++;
            end else begin
               e = expected_tokens.pop_front();
               check_field("record", 32'(e.rec), 32'(rsp_record));
               check_field("token_kind", 32'(e.kind), 32'(rsp_token_kind));
               check_field("error_code", 32'(e.code), 32'(rsp_error_code));
               check_field("payload", 32'(e.pay), 32'(rsp_payload));
               check_field("line_number", 32'(e.line), 32'(rsp_line_number));
               check_field("column", 32'(e.col), 32'(rsp_column));
               check_field("last_of_run", 32'(e.last), 32'(rsp_last_of_run));
            end
         end
      end
   end

   initial fail_count = 0;

endmodule

[tb/script_byte_tokenizer_tb.sv]
// script_byte_tokenizer_tb: drives source text into the tokenizer with random idling
// and stalls; the checker beside the block predicts and compares. Depends on sbt_pkg.
`timescale 1ns / 100ps
module script_byte_tokenizer_tb;
   import sbt_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic        clock;
   logic        reset;
   logic        req_valid, req_stall, req_kind;
   logic [7:0]  req_data_byte;
   logic        rsp_valid, rsp_stall;
   logic [1:0]  rsp_record, rsp_error_code;
   logic [4:0]  rsp_token_kind;
   logic [7:0]  rsp_payload;
   logic [23:0] rsp_line_number;
   logic [15:0] rsp_column;
   logic        rsp_last_of_run;
   int          fail_count, pending;
   int          items_sent;
   int          send_idle_pct, recv_idle_pct;
   int          cycle_count;

   script_byte_tokenizer i_dut (.*);

   script_byte_tokenizer_checker i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   // run guard
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("script_byte_tokenizer: mismatch");
         $finish;
      end
   end

   // receiver: random stalls, plus one long hold-off so the block backs up
   initial begin
      int hold;
      hold = 0;
      rsp_stall = 0;
      forever begin
         @(posedge clock);
         if (items_sent >= 60 && hold == 0) hold = 90;
         if (hold > 1) begin
            hold--;
            rsp_stall <= 1;
         end else begin
            if (hold == 1 && items_sent > 60) hold = -1;
            rsp_stall <= ($urandom_range(0, 99) < recv_idle_pct);
         end
      end
   end

   // one item; waits until the block takes it, valid stays up for the next item
   task automatic send_item(logic kind, logic [7:0] b);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid <= 1;
      req_kind <= kind;
      req_data_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      items_sent++;
      if (items_sent == 130) begin
         send_idle_pct = 45;
         recv_idle_pct = 33;
      end else if (items_sent == 260) begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_item(KIND_BYTE, s[i]);
   endtask

   task automatic end_source();
      send_item(KIND_END, $urandom_range(0, 255));
   endtask

   // one random fragment of source, mostly well formed
   task automatic send_fragment();
      int pick;
      pick = $urandom_range(0, 19);
      case (pick)
         0, 1: send_text("ab_9 ");
         2:    send_text("x1");
         3:    send_text("42.7");
         4:    send_text("6e+12");
         5:    send_text("3E5 ");
         6:    send_text("1e-z");
         7:    send_text("8ex");
         8:    send_text(".5 ");
         9:    send_text(". ");
         10:   send_text("\"q\\n\\t\\\\\\\"z\"");
         11:   send_text("()[],=+-*/%");
         12:   send_text("\n");
         13:   send_text("# note\n");
         14:   send_text("\\\r\n");
         15:   send_text(" \t\r");
         16:   send_text("\"ab\n");
         17:   send_text("\\x");
         default: send_item(KIND_BYTE, $urandom_range(0, 255));
      endcase
   endtask

   initial begin
      reset = 1;
      req_valid = 0;
      req_kind = 0;
      req_data_byte = 0;
      items_sent = 0;
      cycle_count = 0;
      send_idle_pct = 33;
      recv_idle_pct = 45;
      repeat (12) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // full byte-order mark, then mixed tokens and a number with exponent
      send_item(KIND_BYTE, CH_BOM0);
      send_item(KIND_BYTE, CH_BOM1);
      send_item(KIND_BYTE, CH_BOM2);
      send_text("z=.5e+2(");
      end_source();
      // partial byte-order mark, then bytes dropped after the error
      send_item(KIND_BYTE, CH_BOM0);
      send_item(KIND_BYTE, CH_BOM1);
      send_text("a@");
      end_source();
      // partial mark cut off by end of source
      send_item(KIND_BYTE, CH_BOM0);
      end_source();
      // escapes with an escaped newline, then an unterminated string
      send_text("\"\\\n\\e\"\"");
      end_source();
      // backtrack at end, lone backslash, all-ones byte
      send_text("7e-");
      end_source();
      send_text("\\");
      end_source();
      send_item(KIND_BYTE, 8'hFF);
      end_source();

      // random sources
      while (items_sent < 380) begin
         repeat ($urandom_range(2, 10)) send_fragment();
         end_source();
      end
      req_valid <= 0;

      wait (pending == 0);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0)
         $display("script_byte_tokenizer: match");
      else
         $display("script_byte_tokenizer: mismatch");
      $finish;
   end

endmodule

[script_byte_tokenizer.f]
sv/sbt_pkg.sv
sv/sbt_fifo.sv
sv/sbt_front.sv
sv/sbt_back.sv
sv/script_byte_tokenizer.sv
sv/sbt_checker.sv
tb/script_byte_tokenizer_checker.sv
tb/script_byte_tokenizer_tb.sv
